[src/smou_pkg.sv]
// Shared types, constants and helpers for the small matrix operation unit.
`default_nettype none

package smou_pkg;

  localparam int ValW       = 32;
  localparam int DimW       = 4;
  localparam int RowW       = 3;
  localparam int IdxW       = 3;
  localparam int CountW     = 2 * DimW;
  localparam int MaxDimDef  = 8;
  localparam int CmdDepth   = 2;
  localparam int OutDepth   = 4;
  localparam int OutLvlW    = $clog2(OutDepth + 1);

  typedef enum logic [1:0] {
    OP_EQUAL = 2'd0,
    OP_ADD   = 2'd1,
    OP_SUB   = 2'd2,
    OP_MUL   = 2'd3
  } op_e;

  typedef enum logic [IdxW-1:0] {
    REG_OPERATION = 3'd0,
    REG_ROWS_A    = 3'd1,
    REG_COLS_A    = 3'd2,
    REG_ROWS_B    = 3'd3,
    REG_COLS_B    = 3'd4
  } reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_ISSUE
  } st_e;

  typedef struct packed {
    op_e             op;
    logic [DimW-1:0] rows_a;
    logic [DimW-1:0] cols_a;
    logic [DimW-1:0] rows_b;
    logic [DimW-1:0] cols_b;
  } cfg_t;

  typedef struct packed {
    logic            we;
    logic            sel_b;
    logic [ValW-1:0] data;
  } memwr_t;

  typedef struct packed {
    logic            err;
    logic            first;
    logic            emit;
    logic            last;
    logic [RowW-1:0] row;
    logic [RowW-1:0] col;
  } tag_t;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic [RowW-1:0] row;
    logic [RowW-1:0] col;
    logic            equal;
    logic            status;
    logic            last;
  } res_t;

  function automatic logic dim_ok(logic [DimW-1:0] d, logic [DimW:0] max_dim);
    return (d != '0) && ({1'b0, d} <= max_dim);
  endfunction

endpackage

`default_nettype wire

[src/smou_fifo.sv]
// Small synchronous queue used for the command and result paths.
`default_nettype none

module smou_fifo
  import smou_pkg::*;
#(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int LvlW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic             full_o,
  output logic [LvlW-1:0]  level_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [LvlW-1:0]  lvl_q, lvl_d;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    lvl_d    = lvl_q;
    if (do_push) begin
      wr_ptr_d = (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      lvl_d = lvl_q + LvlW'(1);
    end else if (do_pop && !do_push) begin
      lvl_d = lvl_q - LvlW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      lvl_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      lvl_q    <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign empty_o = (lvl_q == '0);
  assign full_o  = (lvl_q == LvlW'(DEPTH));
  assign level_o = lvl_q;

endmodule

`default_nettype wire

[src/smou_front.sv]
// Front end: configuration registers, shape check and element loading.
`default_nettype none

module smou_front
  import smou_pkg::*;
#(
  parameter int MAX_DIM = MaxDimDef,
  localparam int Depth = MAX_DIM * MAX_DIM,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [IdxW-1:0]  cfg_index_i,
  input  logic [DimW-1:0]  cfg_data_i,
  input  logic             push_i,
  input  logic [ValW-1:0]  element_i,
  output logic             full_o,
  output cfg_t             cfg_o,
  output memwr_t           wr_o,
  output logic [AddrW-1:0] wr_addr_o,
  output logic             cmd_push_o,
  output logic             cmd_err_o,
  input  logic             cmd_full_i,
  input  logic             run_done_i
);

  localparam logic [DimW:0] MaxDimV = (DimW + 1)'(MAX_DIM);

  cfg_t              cfg_q, cfg_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              in_b_q, in_b_d;
  logic              run_pend_q, run_pend_d;
  logic [CountW-1:0] na, nb, cnt_inc;
  logic              shp_ok, accept, cfg_hit;

  assign na      = CountW'(cfg_q.rows_a) * CountW'(cfg_q.cols_a);
  assign nb      = CountW'(cfg_q.rows_b) * CountW'(cfg_q.cols_b);
  assign cnt_inc = cnt_q + CountW'(1);

  always_comb begin
    shp_ok = dim_ok(cfg_q.rows_a, MaxDimV) && dim_ok(cfg_q.cols_a, MaxDimV) &&
             dim_ok(cfg_q.rows_b, MaxDimV) && dim_ok(cfg_q.cols_b, MaxDimV);
    if (cfg_q.op == OP_MUL) begin
      shp_ok = shp_ok && (cfg_q.cols_a == cfg_q.rows_b);
    end else begin
      shp_ok = shp_ok && (cfg_q.rows_a == cfg_q.rows_b) && (cfg_q.cols_a == cfg_q.cols_b);
    end
  end

  // A pending run owns the stores until the back end has read its last operands.
  assign full_o = cmd_full_i || run_pend_q;
  assign accept = push_i && !full_o;

  always_comb begin
    cfg_d   = cfg_q;
    cfg_hit = 1'b1;
    if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_OPERATION: cfg_d.op     = op_e'(cfg_data_i[1:0]);
        REG_ROWS_A:    cfg_d.rows_a = cfg_data_i;
        REG_COLS_A:    cfg_d.cols_a = cfg_data_i;
        REG_ROWS_B:    cfg_d.rows_b = cfg_data_i;
        REG_COLS_B:    cfg_d.cols_b = cfg_data_i;
        default:       cfg_hit      = 1'b0;
      endcase
    end else begin
      cfg_hit = 1'b0;
    end
  end

  always_comb begin
    cnt_d      = cnt_q;
    in_b_d     = in_b_q;
    run_pend_d = run_pend_q && !run_done_i;
    cmd_push_o = 1'b0;
    cmd_err_o  = 1'b0;
    wr_o.we    = 1'b0;
    wr_o.sel_b = in_b_q;
    wr_o.data  = element_i;
    wr_addr_o  = cnt_q[AddrW-1:0];
    if (accept) begin
      if (!shp_ok) begin
        cmd_push_o = 1'b1;
        cmd_err_o  = 1'b1;
        cnt_d      = '0;
        in_b_d     = 1'b0;
      end else begin
        wr_o.we = 1'b1;
        if (in_b_q && (cnt_inc == nb)) begin
          cmd_push_o = 1'b1;
          run_pend_d = 1'b1;
          cnt_d      = '0;
          in_b_d     = 1'b0;
        end else if (!in_b_q && (cnt_inc == na)) begin
          cnt_d  = '0;
          in_b_d = 1'b1;
        end else begin
          cnt_d = cnt_inc;
        end
      end
    end
    if (cfg_hit) begin
      cnt_d  = '0;
      in_b_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.op     <= OP_EQUAL;
      cfg_q.rows_a <= DimW'(1);
      cfg_q.cols_a <= DimW'(1);
      cfg_q.rows_b <= DimW'(1);
      cfg_q.cols_b <= DimW'(1);
      cnt_q        <= '0;
      in_b_q       <= 1'b0;
      run_pend_q   <= 1'b0;
    end else begin
      cfg_q      <= cfg_d;
      cnt_q      <= cnt_d;
      in_b_q     <= in_b_d;
      run_pend_q <= run_pend_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[src/smou_back.sv]
// Back end: operand stores, step sequencer and multiply-accumulate datapath.
`default_nettype none

module smou_back
  import smou_pkg::*;
#(
  parameter int MAX_DIM = MaxDimDef,
  localparam int Depth = MAX_DIM * MAX_DIM,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  memwr_t             wr_i,
  input  logic [AddrW-1:0]   wr_addr_i,
  input  logic               cmd_empty_i,
  input  logic               cmd_err_i,
  output logic               cmd_pop_o,
  output logic               run_done_o,
  input  logic [OutLvlW-1:0] out_level_i,
  output logic               res_push_o,
  output res_t               res_o
);

  logic [ValW-1:0] mem_a_q [Depth];
  logic [ValW-1:0] mem_b_q [Depth];

  st_e              st_q, st_d;
  logic [DimW-1:0]  i_q, j_q, k_q;
  logic [AddrW-1:0] a_base_q, b_base_q;
  logic [DimW-1:0]  klim, jlim;
  logic             k_last, j_last, i_last, last_run;
  logic [AddrW-1:0] a_addr, b_addr;
  logic             credit_ok, issue, issue_err, clr_cnt;
  logic [OutLvlW:0] inflight;
  tag_t             tag;

  logic             s1_v_q, s2_v_q;
  tag_t             tag1_q, tag2_q;
  logic [ValW-1:0]  a_rd_q, b_rd_q, val_q, acc_q, acc_sum;
  logic             eq_q, eq_all_q, eq_all;

  // Operand stores.
  always_ff @(posedge clk_i) begin
    if (wr_i.we && !wr_i.sel_b) begin
      mem_a_q[wr_addr_i] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we && wr_i.sel_b) begin
      mem_b_q[wr_addr_i] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      a_rd_q <= mem_a_q[a_addr];
      b_rd_q <= mem_b_q[b_addr];
    end
  end

  // Loop limits: multiplication walks i, j, k; element-wise operations walk i, j.
  assign klim     = (cfg_i.op == OP_MUL) ? cfg_i.cols_a : DimW'(1);
  assign jlim     = (cfg_i.op == OP_MUL) ? cfg_i.cols_b : cfg_i.cols_a;
  assign k_last   = (k_q == klim - DimW'(1));
  assign j_last   = (j_q == jlim - DimW'(1));
  assign i_last   = (i_q == cfg_i.rows_a - DimW'(1));
  assign last_run = i_last && j_last && k_last;
  assign a_addr   = a_base_q + ((cfg_i.op == OP_MUL) ? AddrW'(k_q) : AddrW'(j_q));
  assign b_addr   = (cfg_i.op == OP_MUL) ? b_base_q + AddrW'(j_q) : a_addr;

  // Only issue a step when the result queue can absorb every step in flight.
  assign inflight  = {1'b0, out_level_i} + (OutLvlW + 1)'(s1_v_q) + (OutLvlW + 1)'(s2_v_q);
  assign credit_ok = inflight < (OutLvlW + 1)'(OutDepth);

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (!cmd_empty_i && !cmd_err_i) begin
          st_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (credit_ok && last_run) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o  = 1'b0;
    issue      = 1'b0;
    issue_err  = 1'b0;
    clr_cnt    = 1'b0;
    run_done_o = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          if (cmd_err_i) begin
            if (credit_ok) begin
              cmd_pop_o = 1'b1;
              issue     = 1'b1;
              issue_err = 1'b1;
            end
          end else begin
            cmd_pop_o = 1'b1;
            clr_cnt   = 1'b1;
          end
        end
      end
      ST_ISSUE: begin
        if (credit_ok) begin
          issue      = 1'b1;
          run_done_o = last_run;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    tag.err  = issue_err;
    tag.row  = issue_err ? '0 : i_q[RowW-1:0];
    tag.col  = issue_err ? '0 : j_q[RowW-1:0];
    tag.last = issue_err || last_run;
    if (issue_err) begin
      tag.first = 1'b1;
      tag.emit  = 1'b1;
    end else if (cfg_i.op == OP_EQUAL) begin
      tag.first = (i_q == '0) && (j_q == '0);
      tag.emit  = last_run;
    end else begin
      tag.first = (k_q == '0);
      tag.emit  = k_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      a_base_q <= '0;
      b_base_q <= '0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
      if (clr_cnt) begin
        i_q      <= '0;
        j_q      <= '0;
        k_q      <= '0;
        a_base_q <= '0;
        b_base_q <= '0;
      end else if (issue && !issue_err) begin
        if (!k_last) begin
          k_q      <= k_q + DimW'(1);
          b_base_q <= b_base_q + AddrW'(cfg_i.cols_b);
        end else begin
          k_q      <= '0;
          b_base_q <= '0;
          if (!j_last) begin
            j_q <= j_q + DimW'(1);
          end else begin
            j_q      <= '0;
            i_q      <= i_q + DimW'(1);
            a_base_q <= a_base_q + AddrW'(cfg_i.cols_a);
          end
        end
      end
    end
  end

  // Operand stage to value stage.
  always_ff @(posedge clk_i) begin
    tag1_q <= tag;
    tag2_q <= tag1_q;
    eq_q   <= (a_rd_q == b_rd_q);
    case (cfg_i.op)
      OP_MUL:  val_q <= a_rd_q * b_rd_q;
      OP_ADD:  val_q <= a_rd_q + b_rd_q;
      OP_SUB:  val_q <= a_rd_q - b_rd_q;
      default: val_q <= a_rd_q + b_rd_q;
    endcase
  end

  assign acc_sum = tag2_q.first ? val_q : acc_q + val_q;
  assign eq_all  = tag2_q.first ? eq_q : (eq_all_q && eq_q);

  always_ff @(posedge clk_i) begin
    if (s2_v_q) begin
      acc_q    <= acc_sum;
      eq_all_q <= eq_all;
    end
  end

  always_comb begin
    res_push_o   = s2_v_q && tag2_q.emit;
    res_o.value  = acc_sum;
    res_o.row    = tag2_q.row;
    res_o.col    = tag2_q.col;
    res_o.equal  = 1'b0;
    res_o.status = 1'b0;
    res_o.last   = tag2_q.last;
    if (tag2_q.err) begin
      res_o.value  = '0;
      res_o.status = 1'b1;
    end else if (cfg_i.op == OP_EQUAL) begin
      res_o.value = '0;
      res_o.row   = '0;
      res_o.col   = '0;
      res_o.equal = eq_all;
    end
  end

endmodule

`default_nettype wire

[src/small_matrix_operation_unit.sv]
// Small matrix operation unit: equality, addition, subtraction and product of integer matrices.
//
// Configuration: write a register index and data on cfg_valid_i/cfg_index_i/cfg_data_i;
// cfg_ready_o is always high. Index 0 selects the operation, 1..4 set rows/cols of A and B.
// Any write to a register restarts element loading. Write only while the unit is idle.
// Input: drive element_value_i and raise push while full is low; elements of A come first,
// then those of B, each in row-major order, one element per cycle.
// Output: while empty is low the oldest result sits on the result ports; pop takes it.
// A shape mismatch drops the element and yields one result with status set.
// The sequencer reads the operand stores one step per cycle while the receiver keeps up:
// rows_a*cols_b*cols_a steps for a product, rows_a*cols_a otherwise, one for a mismatch.
// After the last element of B, full stays high until the sequencer has issued the last step
// of the run. A product yields one result per element of A*B once its cols_a steps are summed;
// addition and subtraction yield one per step, and equality one result after its last step.
// The result queue holds four entries; when the receiver stalls, the sequencer pauses and
// nothing is lost. Reset returns all registers to their defaults (equality, 1x1 shapes)
// and empties both queues; the operand stores are not cleared.
`default_nettype none

module small_matrix_operation_unit
  import smou_pkg::*;
#(
  parameter int MAX_DIM = MaxDimDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [IdxW-1:0]        cfg_index_i,
  input  logic [DimW-1:0]        cfg_data_i,
  input  logic                   push,
  output logic                   full,
  input  logic signed [ValW-1:0] element_value_i,
  output logic                   empty,
  input  logic                   pop,
  output logic signed [ValW-1:0] result_value_o,
  output logic [RowW-1:0]        result_row_o,
  output logic [RowW-1:0]        result_col_o,
  output logic                   matrices_equal_o,
  output logic                   status_o,
  output logic                   last_o
);

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  cfg_t               cfg;
  memwr_t             wr;
  logic [AddrW-1:0]   wr_addr;
  logic               cmd_push, cmd_err_in, cmd_full, cmd_empty, cmd_err_out, cmd_pop;
  logic               run_done;
  logic               res_push;
  res_t               res_in, res_out;
  logic [OutLvlW-1:0] out_level;

  assign cfg_ready_o = 1'b1;

  smou_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .element_i   (element_value_i),
    .full_o      (full),
    .cfg_o       (cfg),
    .wr_o        (wr),
    .wr_addr_o   (wr_addr),
    .cmd_push_o  (cmd_push),
    .cmd_err_o   (cmd_err_in),
    .cmd_full_i  (cmd_full),
    .run_done_i  (run_done)
  );

  smou_fifo #(
    .WIDTH (1),
    .DEPTH (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_err_in),
    .pop_i   (cmd_pop),
    .data_o  (cmd_err_out),
    .empty_o (cmd_empty),
    .full_o  (cmd_full),
    .level_o ()
  );

  smou_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .wr_i        (wr),
    .wr_addr_i   (wr_addr),
    .cmd_empty_i (cmd_empty),
    .cmd_err_i   (cmd_err_out),
    .cmd_pop_o   (cmd_pop),
    .run_done_o  (run_done),
    .out_level_i (out_level),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  smou_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty),
    .full_o  (),
    .level_o (out_level)
  );

  assign result_value_o   = res_out.value;
  assign result_row_o     = res_out.row;
  assign result_col_o     = res_out.col;
  assign matrices_equal_o = res_out.equal;
  assign status_o         = res_out.status;
  assign last_o           = res_out.last;

endmodule

`default_nettype wire
